// ----- rtl/rrss_pkg.sv -----
// Package for the round-robin slice scheduler.
// Holds sizes, input kind codes, the table entry type, the scan result type and the FSM states.
// No dependencies.
package rrss_pkg;

  // sizes
  localparam int MAX_PROCS = 64;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 24;
  localparam int VAL_W     = 16;

  // input kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_SLICE = 2'd2;

  // one process table entry
  typedef struct packed {
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] remaining;
  } entry_t;

  // scan outcome: the chosen entry, and whether it was already ready
  typedef struct packed {
    logic             ready;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] remaining;
  } scan_res_t;

  // control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

// ----- rtl/rrss_table.sv -----
// Process table memory: one write port, one read port, read data registered.
// Depends on rrss_pkg.
module rrss_table (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [rrss_pkg::IDX_W-1:0] wr_addr,
  input  rrss_pkg::entry_t      wr_data,
  input  logic [rrss_pkg::IDX_W-1:0] rd_addr,
  output rrss_pkg::entry_t      rd_data
);
  import rrss_pkg::*;

  entry_t mem [MAX_PROCS];

  // synchronous write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // synchronous read, read data registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/rrss_scan.sv -----
// Scan engine: walks the table from the rotating pointer, wrapping, one read per cycle.
// Stops at the first ready entry, else returns the first unfinished entry of earliest arrival.
// Depends on rrss_pkg; drives the read port of rrss_table.
module rrss_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rrss_pkg::IDX_W-1:0]  ptr,
  input  logic [rrss_pkg::CNT_W-1:0]  count,
  input  logic [rrss_pkg::TIME_W-1:0] cur_time,
  output logic [rrss_pkg::IDX_W-1:0]  rd_addr,
  input  rrss_pkg::entry_t            rd_data,
  output logic                        done,
  output rrss_pkg::scan_res_t         res
);
  import rrss_pkg::*;

  logic             busy_r, busy_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             best_vld_r, best_vld_nxt;
  scan_res_t        best_r, best_nxt;
  logic             done_r, done_nxt;

  logic             unfinished;
  logic             ready_now;
  logic             issue;
  logic [CNT_W-1:0] addr_inc;

  // classify the entry returned by the memory
  assign unfinished = pend_r && (rd_data.remaining != '0);
  assign ready_now  = unfinished &&
                      ({{(TIME_W-VAL_W){1'b0}}, rd_data.arrival} <= cur_time);

  assign issue    = busy_r && (left_r != '0) && !ready_now;
  assign addr_inc = {1'b0, addr_r} + CNT_W'(1);
  assign rd_addr  = addr_r;

  // scan sequencing and candidate tracking
  always_comb begin
    busy_nxt     = busy_r;
    addr_nxt     = addr_r;
    left_nxt     = left_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    best_vld_nxt = best_vld_r;
    best_nxt     = best_r;
    done_nxt     = 1'b0;
    if (start) begin
      busy_nxt     = 1'b1;
      addr_nxt     = ptr;
      left_nxt     = count;
      best_vld_nxt = 1'b0;
    end else if (busy_r) begin
      if (issue) begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = addr_r;
        addr_nxt     = (addr_inc == count) ? '0 : addr_inc[IDX_W-1:0];
        left_nxt     = left_r - CNT_W'(1);
      end
      if (ready_now) begin
        best_vld_nxt       = 1'b1;
        best_nxt.ready     = 1'b1;
        best_nxt.idx       = pend_idx_r;
        best_nxt.arrival   = rd_data.arrival;
        best_nxt.remaining = rd_data.remaining;
        busy_nxt           = 1'b0;
        done_nxt           = 1'b1;
      end else begin
        if (unfinished && (!best_vld_r || (rd_data.arrival < best_r.arrival))) begin
          best_vld_nxt       = 1'b1;
          best_nxt.ready     = 1'b0;
          best_nxt.idx       = pend_idx_r;
          best_nxt.arrival   = rd_data.arrival;
          best_nxt.remaining = rd_data.remaining;
        end
        if (!pend_r && (left_r == '0)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pend_r     <= 1'b0;
      done_r     <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      pend_r     <= pend_nxt;
      done_r     <= done_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    left_r     <= left_nxt;
    pend_idx_r <= pend_idx_nxt;
    best_r     <= best_nxt;
  end

  assign done = done_r;
  assign res  = best_r;

endmodule

// ----- rtl/round_robin_slice_scheduler_unit.sv -----
// Round-robin time-slice scheduler, top level: control FSM, scheduler state, result register.
// Depends on rrss_pkg, rrss_table and rrss_scan.
//
// Usage:
//   Input channel (in_valid / in_stall): in_kind selects clear table, load process or
//   request next slice; in_arrival_time and in_burst_time matter for loads only.
//   Result channel (out_valid / out_stall): one transfer per slice request, none for
//   clear or load. The quantum register is written through cfg_wr_en / cfg_wr_data.
//   Clear and load are accepted back to back. A slice request walks the process
//   table through the single read port of the table memory, one entry per cycle:
//   its result is registered once the scan ends (early when a ready process is
//   found), or without a scan when the table is empty or finished; the next
//   item is accepted once that result is registered.
//   in_stall is high while a request is in progress.
//   A finished result sits in the output register; the next item is accepted while
//   it waits. If the receiver still stalls when the next result is ready, that
//   result waits in the control logic and inputs stay stalled.
//   Reset: synchronous, active low; clears the process count, the clock, the pointer
//   and sets quantum to 1. The table memory is not cleared and needs no clearing pass.
module round_robin_slice_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rrss_pkg::VAL_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [rrss_pkg::VAL_W-1:0]  in_arrival_time,
  input  logic [rrss_pkg::VAL_W-1:0]  in_burst_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rrss_pkg::TIME_W-1:0] out_slice_start,
  output logic [rrss_pkg::TIME_W-1:0] out_slice_end,
  output logic [rrss_pkg::IDX_W-1:0]  out_process_id,
  output logic [rrss_pkg::VAL_W-1:0]  out_run_length,
  output logic [rrss_pkg::VAL_W-1:0]  out_time_left,
  output logic                        out_all_done
);
  import rrss_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  fin_r;
  logic [TIME_W-1:0] time_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [VAL_W-1:0]  quantum_r;
  logic              alldone_r;

  logic              out_valid_r;
  logic [TIME_W-1:0] out_start_r;
  logic [TIME_W-1:0] out_end_r;
  logic [IDX_W-1:0]  out_pid_r;
  logic [VAL_W-1:0]  out_run_r;
  logic [VAL_W-1:0]  out_left_r;
  logic              out_done_r;

  logic              in_xfer;
  logic              out_free;
  logic              do_clear, do_load, do_req, do_result;
  logic              scan_start, scan_done;
  scan_res_t         scan_res;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;

  logic [VAL_W-1:0]  q_eff;
  logic [VAL_W-1:0]  run_len;
  logic [TIME_W-1:0] t_start;
  logic [TIME_W-1:0] t_end;
  logic [CNT_W-1:0]  idx_inc;
  logic              table_full;
  logic              all_fin;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign table_full = (count_r >= CNT_W'(MAX_PROCS));
  assign all_fin    = (fin_r >= count_r);

  // slice arithmetic on the chosen entry
  assign q_eff   = (quantum_r == '0) ? VAL_W'(1) : quantum_r;
  assign run_len = (q_eff < scan_res.remaining) ? q_eff : scan_res.remaining;
  assign t_start = scan_res.ready ? time_r : {{(TIME_W-VAL_W){1'b0}}, scan_res.arrival};
  assign t_end   = t_start + {{(TIME_W-VAL_W){1'b0}}, run_len};
  assign idx_inc = {1'b0, scan_res.idx} + CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_kind == KIND_SLICE)) begin
          state_nxt = all_fin ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    do_clear   = 1'b0;
    do_load    = 1'b0;
    do_req     = 1'b0;
    do_result  = 1'b0;
    scan_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        do_clear   = in_xfer && (in_kind == KIND_CLEAR);
        do_load    = in_xfer && (in_kind == KIND_LOAD) && !table_full;
        do_req     = in_xfer && (in_kind == KIND_SLICE);
        scan_start = do_req && !all_fin;
      end
      ST_SCAN:   ;
      ST_RESULT: do_result = out_free;
      default:   ;
    endcase
  end

  // table write port: load appends, result writes back remaining time
  always_comb begin
    wr_en             = 1'b0;
    wr_addr           = count_r[IDX_W-1:0];
    wr_data.arrival   = in_arrival_time;
    wr_data.remaining = in_burst_time;
    if (do_load) begin
      wr_en = 1'b1;
    end else if (do_result && !alldone_r) begin
      wr_en             = 1'b1;
      wr_addr           = scan_res.idx;
      wr_data.arrival   = scan_res.arrival;
      wr_data.remaining = scan_res.remaining - run_len;
    end
  end

  rrss_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrss_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .ptr      (ptr_r),
    .count    (count_r),
    .cur_time (time_r),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .done     (scan_done),
    .res      (scan_res)
  );

  // scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      fin_r     <= '0;
      time_r    <= '0;
      ptr_r     <= '0;
      quantum_r <= VAL_W'(1);
      alldone_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      if (do_clear) begin
        count_r <= '0;
        fin_r   <= '0;
        time_r  <= '0;
        ptr_r   <= '0;
      end
      if (do_load) begin
        count_r <= count_r + CNT_W'(1);
        if (in_burst_time == '0) begin
          fin_r <= fin_r + CNT_W'(1);
        end
      end
      if (do_req) begin
        alldone_r <= all_fin;
      end
      if (do_result && !alldone_r) begin
        time_r <= t_end;
        if (run_len == scan_res.remaining) begin
          fin_r <= fin_r + CNT_W'(1);
        end
        ptr_r <= (idx_inc >= count_r) ? '0 : idx_inc[IDX_W-1:0];
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (do_result) begin
      if (alldone_r) begin
        out_start_r <= time_r;
        out_end_r   <= time_r;
        out_pid_r   <= '0;
        out_run_r   <= '0;
        out_left_r  <= '0;
        out_done_r  <= 1'b1;
      end else begin
        out_start_r <= t_start;
        out_end_r   <= t_end;
        out_pid_r   <= scan_res.idx;
        out_run_r   <= run_len;
        out_left_r  <= scan_res.remaining - run_len;
        out_done_r  <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slice_start = out_start_r;
  assign out_slice_end   = out_end_r;
  assign out_process_id  = out_pid_r;
  assign out_run_length  = out_run_r;
  assign out_time_left   = out_left_r;
  assign out_all_done    = out_done_r;

endmodule

// ----- tb/sv/round_robin_slice_scheduler_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_slice_scheduler_unit: a directed run, then random
// clear/load/slice episodes, all checked against an in-bench round-robin slice predictor.
// Depends on rrss_pkg and the round_robin_slice_scheduler_unit RTL.
module round_robin_slice_scheduler_unit_tb;
  import rrss_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT  = 1_000_000;
  localparam int         SETTLE_CYCLES = 2 * MAX_PROCS + 16;
  localparam int         CHUNK_ITEMS  = 217;

  typedef struct {
    logic [1:0]       kind;
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
  } sched_req_t;

  typedef struct {
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic [IDX_W-1:0]  proc_id;
    logic [VAL_W-1:0]  run_len;
    logic [VAL_W-1:0]  time_left;
    logic              all_done;
  } slice_t;

  // dut ports
  logic              clk;
  logic              rst_n           = 1'b0;
  logic              cfg_wr_en       = 1'b0;
  logic [VAL_W-1:0]  cfg_wr_data     = '0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind         = KIND_CLEAR;
  logic [VAL_W-1:0]  in_arrival_time = '0;
  logic [VAL_W-1:0]  in_burst_time   = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [TIME_W-1:0] out_slice_start;
  logic [TIME_W-1:0] out_slice_end;
  logic [IDX_W-1:0]  out_process_id;
  logic [VAL_W-1:0]  out_run_length;
  logic [VAL_W-1:0]  out_time_left;
  logic              out_all_done;

  // stimulus and expected slices
  sched_req_t request_q[$];
  slice_t     slice_q[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         fail_cnt      = 0;
  int         cycle_cnt     = 0;

  // scheduler state mirror
  logic [VAL_W-1:0]  arr_tbl[MAX_PROCS];
  logic [VAL_W-1:0]  rem_tbl[MAX_PROCS];
  int                proc_cnt  = 0;
  int                done_cnt  = 0;
  logic [TIME_W-1:0] sched_now = '0;
  int                scan_ptr  = 0;
  logic [VAL_W-1:0]  quantum   = 16'd1;

  round_robin_slice_scheduler_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_arrival_time (in_arrival_time),
    .in_burst_time   (in_burst_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slice_start (out_slice_start),
    .out_slice_end   (out_slice_end),
    .out_process_id  (out_process_id),
    .out_run_length  (out_run_length),
    .out_time_left   (out_time_left),
    .out_all_done    (out_all_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // first entry from the pointer, wrapping, that has arrived and has time left
  function automatic int find_ready_proc();
    int idx;
    for (int t = 0; t < proc_cnt; t++) begin
      idx = (scan_ptr + t) % proc_cnt;
      if (TIME_W'(arr_tbl[idx]) <= sched_now && rem_tbl[idx] != 0) return idx;
    end
    return -1;
  endfunction

  // advance the mirrored scheduler by one accepted transfer
  task automatic schedule_request(input sched_req_t r);
    slice_t s;
    int     pid;
    int     earliest;
    int     q;
    int     rem;
    int     run;
    case (r.kind)
      KIND_CLEAR: begin
        proc_cnt  = 0;
        done_cnt  = 0;
        sched_now = '0;
        scan_ptr  = 0;
      end
      KIND_LOAD: begin
        if (proc_cnt < MAX_PROCS) begin
          arr_tbl[proc_cnt] = r.arrival;
          rem_tbl[proc_cnt] = r.burst;
          if (r.burst == 0) done_cnt++;
          proc_cnt++;
        end
      end
      KIND_SLICE: begin
        if (done_cnt >= proc_cnt) begin
          s.slice_start = sched_now;
          s.slice_end   = sched_now;
          s.proc_id     = '0;
          s.run_len     = '0;
          s.time_left   = '0;
          s.all_done    = 1'b1;
        end else begin
          pid = find_ready_proc();
          // nothing ready: jump the clock to the earliest pending arrival
          if (pid < 0) begin
            earliest = -1;
            for (int i = 0; i < proc_cnt; i++) begin
              if (rem_tbl[i] != 0 && (earliest < 0 || int'(arr_tbl[i]) < earliest))
                earliest = arr_tbl[i];
            end
            if (earliest >= 0 && TIME_W'(earliest) > sched_now) sched_now = TIME_W'(earliest);
            pid = find_ready_proc();
            if (pid < 0) pid = 0;
          end
          q   = (quantum == 0) ? 1 : int'(quantum);
          rem = rem_tbl[pid];
          run = (q < rem) ? q : rem;
          s.slice_start = sched_now;
          sched_now     = sched_now + TIME_W'(run);
          rem_tbl[pid]  = VAL_W'(rem - run);
          if (rem != 0 && rem == run) done_cnt++;
          scan_ptr = pid + 1;
          if (scan_ptr >= proc_cnt) scan_ptr = 0;
          s.slice_end = sched_now;
          s.proc_id   = IDX_W'(pid);
          s.run_len   = VAL_W'(run);
          s.time_left = VAL_W'(rem - run);
          s.all_done  = 1'b0;
        end
        slice_q.push_back(s);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] expv,
                             input logic [TIME_W-1:0] gotv);
    if (expv !== gotv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, gotv);
      fail_cnt++;
    end
  endtask

  task automatic push_req(input logic [1:0] k, input logic [VAL_W-1:0] a,
                          input logic [VAL_W-1:0] b);
    sched_req_t r;
    r.kind    = k;
    r.arrival = a;
    r.burst   = b;
    request_q.push_back(r);
  endtask

  function automatic logic [VAL_W-1:0] rand_arrival(input bit wide);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '1;
    if (roll == 1) return '0;
    return wide ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 30));
  endfunction

  function automatic logic [VAL_W-1:0] rand_burst();
    int roll;
    roll = $urandom_range(0, 39);
    if (roll == 0) return '1;
    if (roll < 5) return VAL_W'($urandom_range(1, 65535));
    return VAL_W'($urandom_range(1, 12));
  endfunction

  // one clear/load/slice episode, with late loads, stray clears and unused kinds mixed in
  task automatic add_episode(output int added);
    int  n_procs;
    int  n_slices;
    int  roll;
    bit  wide;
    added = 1;
    push_req(KIND_CLEAR, VAL_W'($urandom), VAL_W'($urandom));
    roll    = $urandom_range(0, 15);
    n_procs = (roll == 0) ? $urandom_range(60, 68) :
              (roll < 3)  ? $urandom_range(9, 24)  : $urandom_range(1, 8);
    wide    = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < n_procs; i++) push_req(KIND_LOAD, rand_arrival(wide), rand_burst());
    added += n_procs;
    n_slices = $urandom_range(1, 2 * n_procs + 4);
    for (int i = 0; i < n_slices; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        push_req(KIND_LOAD, rand_arrival(wide), rand_burst());
        added++;
      end else if (roll < 8) begin
        push_req(KIND_UNUSED, VAL_W'($urandom), VAL_W'($urandom));
      end else if (roll < 9) begin
        push_req(KIND_CLEAR, VAL_W'($urandom), VAL_W'($urandom));
        added++;
      end else begin
        push_req(KIND_SLICE, VAL_W'($urandom), VAL_W'($urandom));
        added++;
      end
    end
  endtask

  // quantum write, only while the block is idle
  task automatic write_quantum(input logic [VAL_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    quantum      = v;
  endtask

  // wait for every transfer and every slice, sampled between edges, then let things settle
  task automatic drain();
    while (request_q.size() != 0 || in_valid || slice_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        schedule_request('{kind: in_kind, arrival: in_arrival_time, burst: in_burst_time});
      if (!in_valid || !in_stall) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid        <= 1'b1;
          in_kind         <= request_q[0].kind;
          in_arrival_time <= request_q[0].arrival;
          in_burst_time   <= request_q[0].burst;
          void'(request_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    slice_t s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (slice_q.size() == 0) begin
          $display("%0t: unexpected slice transfer, process_id %0d", $time, out_process_id);
          fail_cnt++;
        end else begin
          s = slice_q.pop_front();
          check_field("slice_start", s.slice_start, out_slice_start);
          check_field("slice_end", s.slice_end, out_slice_end);
          check_field("process_id", TIME_W'(s.proc_id), TIME_W'(out_process_id));
          check_field("run_length", TIME_W'(s.run_len), TIME_W'(out_run_length));
          check_field("time_left", TIME_W'(s.time_left), TIME_W'(out_time_left));
          check_field("all_done", TIME_W'(s.all_done), TIME_W'(out_all_done));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [VAL_W-1:0] quantum_plan[6];
    int               added;
    int               total;
    quantum_plan = '{16'd1, 16'hFFFF, 16'd0, VAL_W'($urandom_range(2, 16)), 16'd3,
                     VAL_W'($urandom_range(1, 65535))};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 27;
    recv_idle_pct = 86;
    write_quantum(16'd2);

    // directed: empty table, ignored kind, field extremes, zero burst,
    // late load with a past arrival, clear, idle clock jump
    push_req(KIND_SLICE, '0, '0);
    push_req(KIND_UNUSED, '1, '1);
    push_req(KIND_LOAD, 16'd0, 16'd5);
    push_req(KIND_LOAD, '1, '1);
    push_req(KIND_LOAD, 16'd3, 16'd0);
    push_req(KIND_LOAD, 16'd1, 16'd1);
    repeat (5) push_req(KIND_SLICE, '1, '1);
    push_req(KIND_LOAD, 16'd0, 16'd2);
    repeat (5) push_req(KIND_SLICE, '0, '0);
    push_req(KIND_CLEAR, '1, '1);
    push_req(KIND_SLICE, '0, '0);
    push_req(KIND_LOAD, 16'd10, 16'd3);
    repeat (3) push_req(KIND_SLICE, '0, '0);
    push_req(KIND_CLEAR, '0, '0);
    drain();

    // random episodes over several quantum settings and idle patterns
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 86;
        recv_idle_pct = 27;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_quantum(quantum_plan[p]);
      total = 0;
      while (total < CHUNK_ITEMS) begin
        add_episode(added);
        total += added;
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- round_robin_slice_scheduler_unit.f -----
rtl/rrss_pkg.sv
rtl/rrss_table.sv
rtl/rrss_scan.sv
rtl/round_robin_slice_scheduler_unit.sv
tb/sv/round_robin_slice_scheduler_unit_tb.sv
